>>> rtl/tqft_pkg.sv
`default_nettype none
package tqft_pkg;

   // Storage geometry
   localparam int QUEUE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Configuration register widths and reset values
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int CAP_W       = 13;
   localparam int MARK_W      = 12;
   localparam int FREQ_LIM_W  = 15;
   localparam logic [CAP_W-1:0]      CAP_RESET  = 13'd4096;
   localparam logic [MARK_W-1:0]     MARK_RESET = 12'd0;
   localparam logic [FREQ_LIM_W-1:0] FMIN_RESET = 15'd0;
   localparam logic [FREQ_LIM_W-1:0] FMAX_RESET = 15'd4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY  = 3'd0,
      CSR_LOW_MARK  = 3'd1,
      CSR_LOW_EN    = 3'd2,
      CSR_FREQ_MIN  = 3'd3,
      CSR_FREQ_MAX  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_FLUSH   = 2'd2,
      ACT_REMOVE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_INVALID = 3'd2,
      ST_FULL    = 3'd3,
      ST_NO_CHAR = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK_ADDR,
      FSM_WALK_TEST,
      FSM_REPLY
   } state_type;

   // One stored tone
   typedef struct packed {
      logic signed [31:0] duration;
      logic signed [15:0] frequency;
      logic               forever_tone;
      logic               first;
   } tone_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] tone_duration;
      logic signed [15:0] tone_frequency;
      logic               tone_forever;
      logic               tone_first;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_duration;
      logic signed [15:0] out_frequency;
      logic               out_forever;
      logic               out_first;
      logic               low_water_hit;
      logic [12:0]        queue_length;
      logic               queue_full;
   } rsp_type;

   // Tone store access, one write and one read port
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } store_cmd_type;

endpackage
`default_nettype wire

>>> rtl/tone_queue_with_forever_tone.sv
`default_nettype none
// Tone queue: circular FIFO of tones held in a 4096-entry single-port-read RAM.
// Request channel (req_valid / req_stall / req_data) carries one action per
// item: enqueue, dequeue, flush or remove last character. Every item yields
// exactly one result on the rsp channel (rsp_valid / rsp_stall / rsp_data)
// with a status, the dequeued tone, the low-water flag and the queue length.
// Items are handled one at a time. Enqueue, dequeue and flush pass from the
// accept step to the reply step, which writes the result register.
// Remove last character walks back from the tail through the RAM, testing one
// tone per address step and test step (address, then test of the registered
// read data), until a first tone is found or the whole queue length has been
// walked. The registered RAM read is why each tone needs both steps.
// The result register parts the two channels: a new item is taken while the
// previous result still waits; a stalled receiver only holds the reply step.
// Configuration writes (csr_we / csr_index / csr_wdata) take effect at once;
// the user must issue them only while the block is idle (not enforced here).
// Reset (synchronous, active high) empties the queue and restores register
// defaults; RAM contents are not cleared, so no clearing pass is needed.
module tone_queue_with_forever_tone (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire tqft_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output tqft_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [tqft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tqft_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tqft_pkg::*;

   // Configuration registers
   logic [CAP_W-1:0]      cap_ff;
   logic [MARK_W-1:0]     mark_ff;
   logic                  low_en_ff;
   logic [FREQ_LIM_W-1:0] fmin_ff;
   logic [FREQ_LIM_W-1:0] fmax_ff;

   // Queue and sequencer state
   state_type        state_ff,    state_in;
   logic [IDX_W-1:0] head_ff,     head_in;
   logic [IDX_W-1:0] tail_ff,     tail_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CNT_W-1:0] walk_len_ff, walk_len_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic             found_ff,    found_in;
   req_type          req_ff,      req_in;
   rsp_type          rsp_ff,      rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   store_cmd_type    store_cmd;
   tone_type         store_wr;
   tone_type         store_rd;

   logic [CNT_W-1:0] eff_cap;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] tail_next;
   logic [IDX_W-1:0] walk_prev;
   logic             slot_free;
   logic signed [16:0] freq_ext;
   logic signed [16:0] fmin_ext;
   logic signed [16:0] fmax_ext;
   logic             freq_bad;
   logic             deq_hit;

   tqft_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .wr_data (store_wr),
      .rd_data (store_rd)
   );

   // Capacity clamp: zero acts as one, above the depth as the depth
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(QUEUE_DEPTH)) begin
         eff_cap = CNT_W'(QUEUE_DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // Index step unit: wraps at the active capacity
   assign head_next = (({1'b0, head_ff} + 1'b1) >= eff_cap) ? '0 : head_ff + 1'b1;
   assign tail_next = (({1'b0, tail_ff} + 1'b1) >= eff_cap) ? '0 : tail_ff + 1'b1;
   assign walk_prev = (walk_idx_ff == '0) ? IDX_W'(eff_cap - 1'b1) : walk_idx_ff - 1'b1;

   // Enqueue frequency check, signed against unsigned bounds
   assign freq_ext = {req_ff.tone_frequency[15], req_ff.tone_frequency};
   assign fmin_ext = {2'b00, fmin_ff};
   assign fmax_ext = {2'b00, fmax_ff};
   assign freq_bad = (freq_ext < fmin_ext) || (freq_ext > fmax_ext);

   // Low-water crossing on a removing dequeue
   assign deq_hit = low_en_ff && (32'(count_ff) > 32'(mark_ff))
                    && (32'(count_ff) - 32'd1 <= 32'(mark_ff));

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign store_wr = '{duration:     req_ff.tone_duration,
                       frequency:    req_ff.tone_frequency,
                       forever_tone: req_ff.tone_forever,
                       first:        req_ff.tone_first};

   // Sequencer: next state, queue update and result
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      walk_len_in  = walk_len_ff;
      walk_idx_in  = walk_idx_ff;
      found_in     = found_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      store_cmd    = '0;
      req_stall    = 1'b1;

      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in            = req_data;
               // Head read serves a dequeue in the reply step
               store_cmd.rd_en   = 1'b1;
               store_cmd.rd_addr = head_ff;
               if (req_data.action == ACT_REMOVE) begin
                  walk_len_in = count_ff;
                  walk_idx_in = tail_ff;
                  state_in    = FSM_WALK_ADDR;
               end else begin
                  state_in = FSM_REPLY;
               end
            end
         end

         FSM_WALK_ADDR: begin
            if (walk_len_ff == '0) begin
               found_in = 1'b0;
               state_in = FSM_REPLY;
            end else begin
               walk_len_in       = walk_len_ff - 1'b1;
               walk_idx_in       = walk_prev;
               store_cmd.rd_en   = 1'b1;
               store_cmd.rd_addr = walk_prev;
               state_in          = FSM_WALK_TEST;
            end
         end

         FSM_WALK_TEST: begin
            if (store_rd.first) begin
               found_in = 1'b1;
               state_in = FSM_REPLY;
            end else begin
               state_in = FSM_WALK_ADDR;
            end
         end

         FSM_REPLY: begin
            if (slot_free) begin
               rsp_in        = '0;
               rsp_in.status = ST_OK;
               case (req_ff.action)
                  ACT_ENQUEUE: begin
                     if (freq_bad || req_ff.tone_duration[31]) begin
                        rsp_in.status = ST_INVALID;
                     end else if (req_ff.tone_duration == '0) begin
                        rsp_in.status = ST_OK;
                     end else if (count_ff >= eff_cap) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = tail_ff;
                        tail_in           = tail_next;
                        count_in          = count_ff + 1'b1;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_in.out_duration  = store_rd.duration;
                        rsp_in.out_frequency = store_rd.frequency;
                        rsp_in.out_forever   = store_rd.forever_tone;
                        rsp_in.out_first     = store_rd.first;
                        // A lone forever tone stays in place
                        if (!(store_rd.forever_tone && count_ff == CNT_W'(1))) begin
                           head_in              = head_next;
                           count_in             = count_ff - 1'b1;
                           rsp_in.low_water_hit = deq_hit;
                        end
                     end
                  end
                  ACT_FLUSH: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  ACT_REMOVE: begin
                     if (found_ff) begin
                        count_in = walk_len_ff;
                        tail_in  = walk_idx_ff;
                     end else begin
                        rsp_in.status = ST_NO_CHAR;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_OK;
                  end
               endcase
               rsp_in.queue_length = 13'(count_in);
               rsp_in.queue_full   = (count_in >= eff_cap);
               rsp_valid_in        = 1'b1;
               state_in            = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      walk_len_ff <= walk_len_in;
      walk_idx_ff <= walk_idx_in;
      found_ff    <= found_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         mark_ff   <= MARK_RESET;
         low_en_ff <= 1'b0;
         fmin_ff   <= FMIN_RESET;
         fmax_ff   <= FMAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff    <= csr_wdata[CAP_W-1:0];
            CSR_LOW_MARK: mark_ff   <= csr_wdata[MARK_W-1:0];
            CSR_LOW_EN:   low_en_ff <= csr_wdata[0];
            CSR_FREQ_MIN: fmin_ff   <= csr_wdata[FREQ_LIM_W-1:0];
            CSR_FREQ_MAX: fmax_ff   <= csr_wdata[FREQ_LIM_W-1:0];
            default: begin
               cap_ff <= cap_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(QUEUE_DEPTH))
      else $error("tone count above queue depth");

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == FSM_REPLY)
      else $error("result raised outside reply step");

   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_WALK_TEST |-> walk_len_ff < count_ff)
      else $error("walk went past the queue length");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_FULL |-> rsp_ff.queue_full)
      else $error("full status without full flag");

endmodule
`default_nettype wire

>>> rtl/tqft_store.sv
`default_nettype none
module tqft_store (
   input  wire logic                   clock,
   input  wire tqft_pkg::store_cmd_type cmd,
   input  wire tqft_pkg::tone_type     wr_data,
   output tqft_pkg::tone_type          rd_data
);
   import tqft_pkg::*;

   tone_type mem [QUEUE_DEPTH];
   tone_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
   end

   // Registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
